// ===== design/sntvm_pkg.sv =====
// sntvm_pkg: shared types and constants of the trimmed vector mean block.
// Holds the controller-to-datapath command and status structs and the axis codes.
// No dependencies.
`default_nettype none

package sntvm_pkg;

	localparam int unsigned FIELD_W  = 20;
	localparam int unsigned NORM_W   = 40;
	localparam int unsigned CFG_W    = 6;
	localparam int unsigned MIN_N    = 5;
	localparam int unsigned RESET_N  = 11;
	// trimmed entries at each end of the sorted order
	localparam int unsigned TRIM     = 2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [1:0] LAST_CH = 2'd2;

	typedef struct packed {
		logic       wr_en;     // store one input vector
		logic       load_piv;  // capture read data as the pivot vector
		logic       rank_clr;  // clear the pivot rank
		logic       cmp;       // compare read data against the pivot
		logic       j_lt_i;    // compared entry arrived before the pivot
		logic       acc_clr;   // clear the per-axis sums
		logic       acc_add;   // add pivot if its rank is inside the trim window
		logic       div_start; // start dividing the selected axis sum
		logic [1:0] axis;      // axis under division
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

endpackage

`default_nettype wire

// ===== design/sntvm_div.sv =====
// sntvm_div: iterative restoring divider, one quotient bit per cycle.
// Signed dividend over unsigned divisor, quotient truncated toward zero.
// Depends on sntvm_pkg.
`default_nettype none

module sntvm_div #(
	parameter int unsigned SW = 26,
	parameter int unsigned NW = 6
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [SW-1:0]             dividend,
	input  wire logic [NW-1:0]                    divisor,
	output logic                                  done,
	output logic signed [sntvm_pkg::FIELD_W-1:0]  quotient
);

	localparam int unsigned CW = $clog2(SW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic          neg_q;
	logic [NW-1:0] dvs_q;
	logic [NW:0]   trial;
	logic [SW-1:0] quo_signed;

	assign trial = {rem_q, quo_q[SW-1]};

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: shift-subtract on the magnitude
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			quo_q <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= NW'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= NW'(trial);
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
	end

	assign quo_signed = neg_q ? SW'(-quo_q) : quo_q;
	assign quotient   = quo_signed[sntvm_pkg::FIELD_W-1:0];
	assign done       = done_q;

endmodule

`default_nettype wire

// ===== design/sntvm_dp.sv =====
// sntvm_dp: datapath with the vector store, norm squaring, rank counter,
// trimmed sums and divider. Driven by sntvm_ctrl commands; uses sntvm_pkg, sntvm_div.
`default_nettype none

module sntvm_dp #(
	parameter int unsigned MAX_SAMPLES = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire sntvm_pkg::cmd_t                         cmd,
	input  wire logic [$clog2(3*MAX_SAMPLES)-1:0]        wr_addr,
	input  wire logic [$clog2(3*MAX_SAMPLES)-1:0]        rd_addr,
	input  wire logic [$clog2(MAX_SAMPLES+1)-1:0]        n_eff,
	input  wire logic signed [sntvm_pkg::FIELD_W-1:0]    x,
	input  wire logic signed [sntvm_pkg::FIELD_W-1:0]    y,
	input  wire logic signed [sntvm_pkg::FIELD_W-1:0]    z,
	output sntvm_pkg::stat_t                             stat,
	output logic signed [sntvm_pkg::FIELD_W-1:0]         mean_x,
	output logic signed [sntvm_pkg::FIELD_W-1:0]         mean_y,
	output logic signed [sntvm_pkg::FIELD_W-1:0]         mean_z
);

	localparam int unsigned FW    = sntvm_pkg::FIELD_W;
	localparam int unsigned NMW   = sntvm_pkg::NORM_W;
	localparam int unsigned DEPTH = 3 * MAX_SAMPLES;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned NW    = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned RW    = $clog2(MAX_SAMPLES);
	localparam int unsigned SW    = FW + $clog2(MAX_SAMPLES) + 1;
	localparam int unsigned MW    = 3 * FW + NMW;

	// vector store, one word per item: {x, y, z, norm}
	logic [MW-1:0] mem_q [DEPTH];
	logic [MW-1:0] rd_q;

	logic                  wr_s1;
	logic [AW-1:0]         addr_s1;
	logic signed [FW-1:0]  x_s1, y_s1, z_s1;
	logic signed [NMW-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic [NMW-1:0]        norm_sum;

	logic [NMW-1:0]        piv_norm_q;
	logic signed [FW-1:0]  piv_x_q, piv_y_q, piv_z_q;
	logic [RW-1:0]         rank_q;
	logic signed [SW-1:0]  sx_q, sy_q, sz_q;
	logic                  in_window;
	logic [NMW-1:0]        rd_norm;

	logic signed [SW-1:0]  div_dividend;
	logic [NW-1:0]         div_divisor;
	logic                  div_done;
	logic signed [FW-1:0]  div_quo;
	logic signed [FW-1:0]  mx_q, my_q, mz_q;

	// stage 1: register the squares of an incoming vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= cmd.wr_en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= wr_addr;
		x_s1    <= x;
		y_s1    <= y;
		z_s1    <= z;
		sqx_s1  <= NMW'(x) * NMW'(x);
		sqy_s1  <= NMW'(y) * NMW'(y);
		sqz_s1  <= NMW'(z) * NMW'(z);
	end

	assign norm_sum = NMW'($unsigned(sqx_s1) + $unsigned(sqy_s1) + $unsigned(sqz_s1));

	// store write and registered read
	always_ff @(posedge clk) begin
		if (wr_s1) begin
			mem_q[addr_s1] <= {x_s1, y_s1, z_s1, norm_sum};
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_norm = rd_q[NMW-1:0];

	// pivot capture
	always_ff @(posedge clk) begin
		if (cmd.load_piv) begin
			piv_x_q    <= rd_q[MW-1 -: FW];
			piv_y_q    <= rd_q[MW-FW-1 -: FW];
			piv_z_q    <= rd_q[MW-2*FW-1 -: FW];
			piv_norm_q <= rd_norm;
		end
	end

	// stable rank: entries strictly smaller, or equal and earlier
	always_ff @(posedge clk) begin
		if (cmd.rank_clr) begin
			rank_q <= '0;
		end else if (cmd.cmp) begin
			if ((rd_norm < piv_norm_q) || ((rd_norm == piv_norm_q) && cmd.j_lt_i)) begin
				rank_q <= rank_q + RW'(1);
			end
		end
	end

	// pivot kept when its rank is between TRIM and n-1-TRIM
	always_comb begin
		in_window = (int'(rank_q) >= int'(sntvm_pkg::TRIM)) &&
			(int'(rank_q) <= int'(n_eff) - 1 - int'(sntvm_pkg::TRIM));
	end

	// per-axis sums
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
		end else if (cmd.acc_add && in_window) begin
			sx_q <= sx_q + SW'(piv_x_q);
			sy_q <= sy_q + SW'(piv_y_q);
			sz_q <= sz_q + SW'(piv_z_q);
		end
	end

	// divider operand select
	always_comb begin
		case (cmd.axis)
			sntvm_pkg::AXIS_X: div_dividend = sx_q;
			sntvm_pkg::AXIS_Y: div_dividend = sy_q;
			sntvm_pkg::AXIS_Z: div_dividend = sz_q;
			default:           div_dividend = sz_q;
		endcase
	end

	assign div_divisor = n_eff - NW'(2 * sntvm_pkg::TRIM);

	sntvm_div #(
		.SW(SW),
		.NW(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// result registers
	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.axis)
				sntvm_pkg::AXIS_X: mx_q <= div_quo;
				sntvm_pkg::AXIS_Y: my_q <= div_quo;
				sntvm_pkg::AXIS_Z: mz_q <= div_quo;
				default:           mz_q <= div_quo;
			endcase
		end
	end

	assign stat.div_done = div_done;
	assign mean_x = mx_q;
	assign mean_y = my_q;
	assign mean_z = mz_q;

endmodule

`default_nettype wire

// ===== design/sntvm_ctrl.sv =====
// sntvm_ctrl: controller FSM; holds sample_count, item counter and the
// rank/sum/divide sequencer. Uses sntvm_pkg.
`default_nettype none

module sntvm_ctrl #(
	parameter int unsigned MAX_SAMPLES = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic                                cfg_valid,
	input  wire logic [sntvm_pkg::CFG_W-1:0]         cfg_data,
	input  wire sntvm_pkg::stat_t                    stat,
	output logic                                     busy,
	output logic                                     cfg_ready,
	output sntvm_pkg::cmd_t                          cmd,
	output logic [$clog2(3*MAX_SAMPLES)-1:0]         wr_addr,
	output logic [$clog2(3*MAX_SAMPLES)-1:0]         rd_addr,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]         n_eff,
	output logic                                     result_valid,
	output logic [1:0]                               channel,
	output logic                                     last
);

	localparam int unsigned AW = $clog2(3 * MAX_SAMPLES);
	localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned RW = $clog2(MAX_SAMPLES);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_WAIT  = 4'd1;
	localparam logic [3:0] S_PRD   = 4'd2;
	localparam logic [3:0] S_PLD   = 4'd3;
	localparam logic [3:0] S_JRD   = 4'd4;
	localparam logic [3:0] S_JCMP  = 4'd5;
	localparam logic [3:0] S_ADD   = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_DWAIT = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0]                  state_q;
	logic [sntvm_pkg::CFG_W-1:0] count_q;
	logic [AW-1:0]               k_q;
	logic [RW-1:0]               i_q, j_q;
	logic [1:0]                  ch_q;
	logic [1:0]                  axis_q;
	logic                        accept;
	logic                        k_last, i_last, j_last;

	// clamp the configured count to the legal range
	always_comb begin
		int unsigned sc;
		sc = int'(count_q);
		if (sc < sntvm_pkg::MIN_N) begin
			sc = sntvm_pkg::MIN_N;
		end
		if (sc > MAX_SAMPLES) begin
			sc = MAX_SAMPLES;
		end
		n_eff = NW'(sc);
	end

	assign busy      = (state_q != S_LOAD);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign k_last    = (int'(k_q) == 3 * int'(n_eff) - 1);
	assign i_last    = (int'(i_q) == int'(n_eff) - 1);
	assign j_last    = (int'(j_q) == int'(n_eff) - 1);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= sntvm_pkg::CFG_W'(sntvm_pkg::RESET_N);
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			ch_q    <= '0;
			axis_q  <= sntvm_pkg::AXIS_X;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (cfg_valid) begin
						count_q <= cfg_data;
						k_q     <= '0;
					end else if (accept) begin
						if (k_last) begin
							k_q     <= '0;
							state_q <= S_WAIT;
						end else begin
							k_q <= k_q + AW'(1);
						end
					end
					ch_q <= '0;
					i_q  <= '0;
				end
				S_WAIT: begin
					state_q <= S_PRD;
				end
				S_PRD: begin
					state_q <= S_PLD;
				end
				S_PLD: begin
					j_q     <= '0;
					state_q <= S_JRD;
				end
				S_JRD: begin
					state_q <= S_JCMP;
				end
				S_JCMP: begin
					if (j_last) begin
						state_q <= S_ADD;
					end else begin
						j_q     <= j_q + RW'(1);
						state_q <= S_JRD;
					end
				end
				S_ADD: begin
					if (i_last) begin
						axis_q  <= sntvm_pkg::AXIS_X;
						state_q <= S_DIV;
					end else begin
						i_q     <= i_q + RW'(1);
						state_q <= S_PRD;
					end
				end
				S_DIV: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (stat.div_done) begin
						if (axis_q == sntvm_pkg::AXIS_Z) begin
							state_q <= S_OUT;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_OUT: begin
					i_q <= '0;
					if (ch_q == sntvm_pkg::LAST_CH) begin
						state_q <= S_LOAD;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= S_PRD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// store addresses: item k, or element i/j of channel ch at 3*index+ch
	assign wr_addr = k_q;
	always_comb begin
		if (state_q == S_JRD) begin
			rd_addr = AW'(3 * int'(j_q) + int'(ch_q));
		end else begin
			rd_addr = AW'(3 * int'(i_q) + int'(ch_q));
		end
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.wr_en     = accept && !cfg_valid;
		cmd.load_piv  = (state_q == S_PLD);
		cmd.rank_clr  = (state_q == S_PLD);
		cmd.cmp       = (state_q == S_JCMP);
		cmd.j_lt_i    = (j_q < i_q);
		cmd.acc_clr   = (state_q == S_WAIT) || (state_q == S_OUT);
		cmd.acc_add   = (state_q == S_ADD);
		cmd.div_start = (state_q == S_DIV);
		cmd.axis      = axis_q;
	end

	assign result_valid = (state_q == S_OUT);
	assign channel      = ch_q;
	assign last         = (ch_q == sntvm_pkg::LAST_CH);

endmodule

`default_nettype wire

// ===== design/norm_sorted_trimmed_vector_mean.sv =====
// Trimmed mean of interleaved sensor vectors ranked by squared norm.
// Load: one vector per cycle; busy rises after the last of the 3*N vectors of a batch.
// Busy phase per channel: rank counting (one store read port, a read state and a
// compare state per compare), then 3 serial divides, one per axis,
// and a result strobe; results are three one-cycle strobes.
// Reset (async, active low) clears counters, N to 11.
`default_nettype none

module norm_sorted_trimmed_vector_mean #(
	parameter int unsigned MAX_SAMPLES = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [sntvm_pkg::FIELD_W-1:0]  x,
	input  wire logic signed [sntvm_pkg::FIELD_W-1:0]  y,
	input  wire logic signed [sntvm_pkg::FIELD_W-1:0]  z,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [sntvm_pkg::CFG_W-1:0]           cfg_data,
	output logic                                       result_valid,
	output logic [1:0]                                 channel,
	output logic signed [sntvm_pkg::FIELD_W-1:0]       mean_x,
	output logic signed [sntvm_pkg::FIELD_W-1:0]       mean_y,
	output logic signed [sntvm_pkg::FIELD_W-1:0]       mean_z,
	output logic                                       last
);

	localparam int unsigned AW = $clog2(3 * MAX_SAMPLES);
	localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);

	sntvm_pkg::cmd_t  cmd;
	sntvm_pkg::stat_t stat;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [NW-1:0]    n_eff;

	sntvm_ctrl #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.stat         (stat),
		.busy         (busy),
		.cfg_ready    (cfg_ready),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.n_eff        (n_eff),
		.result_valid (result_valid),
		.channel      (channel),
		.last         (last)
	);

	sntvm_dp #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.n_eff   (n_eff),
		.x       (x),
		.y       (y),
		.z       (z),
		.stat    (stat),
		.mean_x  (mean_x),
		.mean_y  (mean_y),
		.mean_z  (mean_z)
	);

endmodule

`default_nettype wire

// ===== design/sntvm_chk.sv =====
// sntvm_chk: port-level checks on the result strobe sequence and busy.
// Bound to norm_sorted_trimmed_vector_mean; depends on sntvm_pkg.
`default_nettype none

module sntvm_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       busy,
	input wire logic       result_valid,
	input wire logic [1:0] channel,
	input wire logic       last
);

	// results only come out while busy
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside busy phase");

	// last marks the final channel
	a_last_ch: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> channel == sntvm_pkg::LAST_CH)
		else $error("last on wrong channel");

	// block returns to idle right after the final result
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !busy) else $error("still busy after batch");

	// results of one batch are separated by compute cycles
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> !result_valid) else $error("back-to-back results");

	// a result that is not last is never on the final channel
	a_ch_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> channel != sntvm_pkg::LAST_CH)
		else $error("channel order broken");

endmodule

bind norm_sorted_trimmed_vector_mean sntvm_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.result_valid (result_valid),
	.channel      (channel),
	.last         (last)
);

`default_nettype wire

// ===== tb/sv/norm_sorted_trimmed_vector_mean_tb.sv =====
// Self-checking testbench for norm_sorted_trimmed_vector_mean.
// Drives batches of vectors and sample_count writes through a queue-fed driver, predicts
// the three trimmed channel means per batch, and checks them. Depends on sntvm_pkg.
`default_nettype none

module norm_sorted_trimmed_vector_mean_tb;

	localparam int unsigned MAX_N     = 32;
	localparam int unsigned DEPTH     = 3 * MAX_N;
	localparam int unsigned SETTLE    = 64;
	localparam int unsigned WDOG_MAX  = 40000;
	localparam int unsigned ITEMS_TGT = 270;
	localparam logic signed [sntvm_pkg::FIELD_W-1:0] F_MAX = 20'sh7FFFF;
	localparam logic signed [sntvm_pkg::FIELD_W-1:0] F_MIN = -20'sh80000;

	// one pending transaction: a vector or a sample_count write
	typedef struct {
		bit                                   is_cfg;
		logic [sntvm_pkg::CFG_W-1:0]          count;
		logic signed [sntvm_pkg::FIELD_W-1:0] vx, vy, vz;
		int unsigned                          gap;
	} txn_t;

	typedef struct {
		logic [1:0]                           ch;
		logic signed [sntvm_pkg::FIELD_W-1:0] mx, my, mz;
		logic                                 is_last;
	} chan_mean_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 start = 1'b0;
	logic                                 busy;
	logic signed [sntvm_pkg::FIELD_W-1:0] x = '0, y = '0, z = '0;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [sntvm_pkg::CFG_W-1:0]          cfg_data = '0;
	logic                                 result_valid;
	logic [1:0]                           channel;
	logic signed [sntvm_pkg::FIELD_W-1:0] mean_x, mean_y, mean_z;
	logic                                 last;

	txn_t        pending_q[$];
	chan_mean_t  mean_q[$];
	int unsigned errors = 0;
	int unsigned quiet = 0;
	int unsigned idle_cycles = 0;
	int unsigned gap_left = 0;
	txn_t        head;

	// predictor state
	logic [sntvm_pkg::CFG_W-1:0]          count_reg = sntvm_pkg::CFG_W'(sntvm_pkg::RESET_N);
	int unsigned                          batch_fill = 0;
	logic signed [sntvm_pkg::FIELD_W-1:0] vec_x[DEPTH], vec_y[DEPTH], vec_z[DEPTH];
	longint                               vec_norm[DEPTH];

	norm_sorted_trimmed_vector_mean #(.MAX_SAMPLES(MAX_N)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x(x), .y(y), .z(z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .channel(channel),
		.mean_x(mean_x), .mean_y(mean_y), .mean_z(mean_z), .last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned clamped_n(logic [sntvm_pkg::CFG_W-1:0] c);
		if (c < sntvm_pkg::MIN_N) return sntvm_pkg::MIN_N;
		if (c > MAX_N) return MAX_N;
		return c;
	endfunction

	// stable rank by norm per channel, trim both ends, truncating mean per axis
	function automatic void trimmed_batch_means(int unsigned n);
		int unsigned order[MAX_N];
		int unsigned cur, j;
		longint sx, sy, sz;
		chan_mean_t m;
		for (int ch = 0; ch < 3; ch++) begin
			for (int unsigned i = 0; i < n; i++) begin
				cur = i * 3 + ch;
				j = i;
				while (j > 0 && vec_norm[order[j-1]] > vec_norm[cur]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = cur;
			end
			sx = 0; sy = 0; sz = 0;
			for (int unsigned i = sntvm_pkg::TRIM; i < n - sntvm_pkg::TRIM; i++) begin
				sx += vec_x[order[i]];
				sy += vec_y[order[i]];
				sz += vec_z[order[i]];
			end
			m.ch = ch[1:0];
			m.mx = sntvm_pkg::FIELD_W'(sx / longint'(n - 4));
			m.my = sntvm_pkg::FIELD_W'(sy / longint'(n - 4));
			m.mz = sntvm_pkg::FIELD_W'(sz / longint'(n - 4));
			m.is_last = (m.ch == sntvm_pkg::LAST_CH);
			mean_q.push_back(m);
		end
	endfunction

	function automatic void store_vector(txn_t t);
		int unsigned n;
		n = clamped_n(count_reg);
		if (batch_fill >= 3 * n) batch_fill = 0;
		vec_x[batch_fill] = t.vx;
		vec_y[batch_fill] = t.vy;
		vec_z[batch_fill] = t.vz;
		vec_norm[batch_fill] = longint'(t.vx) * t.vx + longint'(t.vy) * t.vy
			+ longint'(t.vz) * t.vz;
		batch_fill++;
		if (batch_fill == 3 * n) begin
			batch_fill = 0;
			trimmed_batch_means(n);
		end
	endfunction

	// driver: one transaction at a time, config only once the block has drained
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (start && !busy) begin
				store_vector(pending_q.pop_front());
				gap_left = head.gap;
			end else if (cfg_valid && cfg_ready) begin
				head = pending_q.pop_front();
				count_reg = head.count;
				batch_fill = 0;
				gap_left = head.gap;
			end
			if (!((start && busy) || (cfg_valid && !cfg_ready))) begin
				if (gap_left > 0 || pending_q.size() == 0) begin
					if (gap_left > 0) gap_left--;
					start <= 1'b0;
					cfg_valid <= 1'b0;
				end else begin
					head = pending_q[0];
					if (head.is_cfg) begin
						start <= 1'b0;
						cfg_data <= head.count;
						cfg_valid <= (mean_q.size() == 0 && !busy && quiet >= SETTLE);
					end else begin
						cfg_valid <= 1'b0;
						start <= 1'b1;
						x <= head.vx;
						y <= head.vy;
						z <= head.vz;
					end
				end
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet <= result_valid ? 0 : quiet + 1;
			if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_MAX) begin
				$display("DONE: errors detected");
				$finish;
			end
			if (result_valid) begin
				if (mean_q.size() == 0) begin
					$error("unexpected result on channel %0d", channel);
					errors++;
				end else begin
					chan_mean_t e;
					e = mean_q.pop_front();
					if (channel !== e.ch) begin
						$error("channel: expected %0d, got %0d", e.ch, channel);
						errors++;
					end
					if (mean_x !== e.mx) begin
						$error("mean_x: expected %0d, got %0d", e.mx, mean_x);
						errors++;
					end
					if (mean_y !== e.my) begin
						$error("mean_y: expected %0d, got %0d", e.my, mean_y);
						errors++;
					end
					if (mean_z !== e.mz) begin
						$error("mean_z: expected %0d, got %0d", e.mz, mean_z);
						errors++;
					end
					if (last !== e.is_last) begin
						$error("last: expected %0d, got %0d", e.is_last, last);
						errors++;
					end
				end
			end
		end
	end

	// gap before the next transaction: mostly none, some short, a few long
	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [sntvm_pkg::FIELD_W-1:0] pick_field();
		case ($urandom_range(0, 7))
			0: return F_MAX;
			1: return F_MIN;
			2: return sntvm_pkg::FIELD_W'($urandom_range(0, 16)) - 20'sd8;
			default: return sntvm_pkg::FIELD_W'($urandom);
		endcase
	endfunction

	task automatic add_cfg(logic [sntvm_pkg::CFG_W-1:0] c);
		txn_t t;
		t = '{1'b1, c, '0, '0, '0, 0};
		pending_q.push_back(t);
	endtask

	task automatic add_vec(logic signed [sntvm_pkg::FIELD_W-1:0] a, b, c, bit calm);
		txn_t t;
		t = '{1'b0, '0, a, b, c, pick_gap(calm)};
		pending_q.push_back(t);
	endtask

	// random vectors; some repeat or mirror an earlier one to force norm ties
	task automatic add_random(int unsigned cnt, bit calm);
		logic signed [sntvm_pkg::FIELD_W-1:0] a, b, c;
		a = '0; b = '0; c = '0;
		repeat (cnt) begin
			case ($urandom_range(0, 9))
				0: ;
				1: begin a = -a; c = -c; end
				2: begin a = b; b = c; c = a; end
				default: begin a = pick_field(); b = pick_field(); c = pick_field(); end
			endcase
			add_vec(a, b, c, calm);
		end
	endtask

	initial begin
		int unsigned total;
		int unsigned n;
		int unsigned reps;
		int unsigned part;
		logic [sntvm_pkg::CFG_W-1:0] c;

		// directed: count below range clamps to 5, field extremes and ties
		add_cfg(6'd0);
		add_vec(F_MAX, F_MAX, F_MAX, 1'b1);
		add_vec(F_MIN, F_MIN, F_MIN, 1'b1);
		add_vec('0, '0, '0, 1'b1);
		add_vec(F_MIN, F_MAX, '0, 1'b0);
		add_vec(F_MAX, F_MIN, '0, 1'b0);
		add_vec('0, '0, '0, 1'b0);
		add_vec(20'sd3, -20'sd4, '0, 1'b1);
		add_vec(-20'sd5, '0, '0, 1'b1);
		add_vec(20'sd1, 20'sd1, 20'sd1, 1'b1);
		add_vec(-20'sd3, 20'sd4, '0, 1'b0);
		add_vec('0, 20'sd5, '0, 1'b0);
		add_vec(-20'sd1, -20'sd1, -20'sd1, 1'b0);
		add_vec('0, '0, -20'sd5, 1'b1);
		add_vec(F_MAX, '0, F_MIN, 1'b1);
		add_vec(20'sd7, -20'sd7, 20'sd7, 1'b1);
		// write during a partial batch discards it
		add_cfg(6'd7);
		add_random(10, 1'b0);
		add_cfg(6'd5);
		total = 25;

		// extremes of the count: above range, top, just below minimum
		add_cfg(6'd63);
		add_random(96, 1'b0);
		add_cfg(6'd4);
		add_random(15, 1'b1);
		add_cfg(6'd33);
		add_random(20, 1'b0);
		add_cfg(6'd32);
		add_random(10, 1'b0);
		total += 141;

		// random phases, mostly small counts, some with a trailing partial batch
		while (total < ITEMS_TGT) begin
			case ($urandom_range(0, 9))
				0: c = 6'($urandom_range(0, 4));
				1: c = 6'($urandom_range(33, 63));
				default: c = 6'($urandom_range(5, 10));
			endcase
			n = clamped_n(c);
			if (n > 12 && $urandom_range(0, 1)) c = 6'd6;
			n = clamped_n(c);
			add_cfg(c);
			reps = $urandom_range(1, 2);
			add_random(3 * n * reps, $urandom_range(0, 3) == 0);
			total += 3 * n * reps;
			if ($urandom_range(0, 3) == 0) begin
				part = $urandom_range(1, 3 * n - 1);
				add_random(part, 1'b0);
				total += part;
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_q.size() != 0 || mean_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
